// File: rtl/core/rdss_pkg.sv
// Package for the record deframer and sample scaler: result types, kind codes,
// the fixed field widths and the sample scaling function.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rdss_pkg;

    // Field widths fixed by the stream format
    localparam int BYTE_W   = 8;
    localparam int OFFSET_W = 5;

    // Default header length in bytes
    localparam int HEADER_BYTES_DEF = 28;

    // Separator byte and the offset from which a 0xFF may start a terminator
    localparam logic [BYTE_W-1:0]   SEP_BYTE       = 8'hFF;
    localparam logic [OFFSET_W-1:0] TERM_MIN_OFFSET = 5'd2;

    // Scale by 127/100: (b * 5202) >> 12 equals floor(b * 127 / 100) for b up to 100.
    // Above 100 the result saturates.
    localparam int                SCALE_SHIFT = 12;
    localparam logic [12:0]       SCALE_MULT  = 13'd5202;
    localparam logic [BYTE_W-1:0] SAT_LIMIT   = 8'd100;
    localparam logic [BYTE_W-1:0] SAMPLE_MAX  = 8'd127;

    // Output queue depth and its index widths
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_SAMPLE = 2'd1,
        KIND_END    = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t               kind;
        logic [BYTE_W-1:0]   value;
        logic [OFFSET_W-1:0] hidx;
        logic                chan;
        logic                last;
    } result_t;

    // Up to two results produced by one input byte
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } pair_t;

    function automatic logic [BYTE_W-1:0] scale_sample(input logic [BYTE_W-1:0] b);
        logic [20:0] prod;
        prod = 21'(b) * 21'(SCALE_MULT);
        if (b > SAT_LIMIT)
            return SAMPLE_MAX;
        else
            return prod[SCALE_SHIFT +: BYTE_W];
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/rdss_deframer.sv
// Record deframer: hunt, skip and record states, held 0xFF handling and
// formation of up to two results per byte. Depends on rdss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rdss_deframer #(
    parameter int HEADER_BYTES = rdss_pkg::HEADER_BYTES_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        accept,
    input  wire logic [rdss_pkg::BYTE_W-1:0] in_byte,
    output rdss_pkg::pair_t                  pair
);
    import rdss_pkg::*;

    typedef enum logic [1:0] {
        MODE_HUNT = 2'd0,
        MODE_SKIP = 2'd1,
        MODE_REC  = 2'd2
    } mode_t;

    localparam logic [OFFSET_W-1:0] HDR_LEN = OFFSET_W'(HEADER_BYTES);

    mode_t               mode_reg,   mode_next;
    logic                held_reg,   held_next;
    logic [OFFSET_W-1:0] offset_reg, offset_next;
    logic                tog_reg,    tog_next;

    function automatic result_t emit_res(input logic [BYTE_W-1:0] b,
                                         input logic [OFFSET_W-1:0] off,
                                         input logic tog);
        result_t r;
        r.last = 1'b0;
        if (off < HDR_LEN) begin
            r.kind  = KIND_HEADER;
            r.value = b;
            r.hidx  = off;
            r.chan  = 1'b0;
        end
        else begin
            r.kind  = KIND_SAMPLE;
            r.value = scale_sample(b);
            r.hidx  = '0;
            r.chan  = tog;
        end
        return r;
    endfunction

    function automatic logic [OFFSET_W-1:0] adv_off(input logic [OFFSET_W-1:0] off);
        return (off < HDR_LEN) ? off + OFFSET_W'(1) : off;
    endfunction

    function automatic logic adv_tog(input logic [OFFSET_W-1:0] off, input logic tog);
        return (off < HDR_LEN) ? tog : ~tog;
    endfunction

    logic                is_ff;
    logic [OFFSET_W-1:0] off_mid;
    logic                tog_mid;
    result_t             end_res;
    pair_t               pair_raw;

    always_comb
    begin
        is_ff          = (in_byte == SEP_BYTE);
        end_res        = '{kind: KIND_END, value: '0, hidx: '0, chan: 1'b0, last: 1'b0};
        mode_next      = mode_reg;
        held_next      = held_reg;
        offset_next    = offset_reg;
        tog_next       = tog_reg;
        off_mid        = offset_reg;
        tog_mid        = tog_reg;
        pair_raw       = '0;
        pair_raw.first  = end_res;
        pair_raw.second = end_res;

        case (mode_reg)
            MODE_SKIP:
            begin
                held_next = 1'b0;
                if (!is_ff)
                begin
                    mode_next      = MODE_REC;
                    pair_raw.count = 2'd1;
                    pair_raw.first = emit_res(in_byte, '0, 1'b0);
                    offset_next    = adv_off('0);
                    tog_next       = adv_tog('0, 1'b0);
                end
            end
            MODE_REC:
            begin
                if (held_reg)
                begin
                    held_next = 1'b0;
                    if (is_ff)
                    begin
                        pair_raw.count = 2'd1;
                        mode_next      = MODE_SKIP;
                    end
                    else
                    begin
                        // Release the held 0xFF as data, then this byte
                        pair_raw.count  = 2'd2;
                        pair_raw.first  = emit_res(SEP_BYTE, offset_reg, tog_reg);
                        off_mid         = adv_off(offset_reg);
                        tog_mid         = adv_tog(offset_reg, tog_reg);
                        pair_raw.second = emit_res(in_byte, off_mid, tog_mid);
                        offset_next     = adv_off(off_mid);
                        tog_next        = adv_tog(off_mid, tog_mid);
                    end
                end
                else if (is_ff && offset_reg >= TERM_MIN_OFFSET)
                begin
                    held_next = 1'b1;
                end
                else
                begin
                    pair_raw.count = 2'd1;
                    pair_raw.first = emit_res(in_byte, offset_reg, tog_reg);
                    offset_next    = adv_off(offset_reg);
                    tog_next       = adv_tog(offset_reg, tog_reg);
                end
            end
            default:
            begin
                // Hunting, and the unused code behaves the same
                mode_next = MODE_HUNT;
                if (is_ff && held_reg)
                begin
                    mode_next = MODE_SKIP;
                    held_next = 1'b0;
                end
                else
                begin
                    held_next = is_ff;
                end
            end
        endcase

        if (pair_raw.count == 2'd1)
            pair_raw.first.last = 1'b1;
        if (pair_raw.count == 2'd2)
            pair_raw.second.last = 1'b1;
    end

    assign pair = pair_raw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_HUNT;
            held_reg   <= 1'b0;
            offset_reg <= '0;
            tog_reg    <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg   <= mode_next;
            held_reg   <= held_next;
            offset_reg <= offset_next;
            tog_reg    <= tog_next;
        end
    end

    a_no_hold_in_skip : assert property (@(posedge clk) disable iff (!rst_n)
        !(mode_reg == MODE_SKIP && held_reg))
        else $error("held 0xFF flag set while skipping separators");

    a_end_needs_hold : assert property (@(posedge clk) disable iff (!rst_n)
        (pair_raw.count != 2'd0 && pair_raw.first.kind == KIND_END)
            |-> (held_reg && mode_reg == MODE_REC))
        else $error("record end formed without a held 0xFF");

    a_pair_channels : assert property (@(posedge clk) disable iff (!rst_n)
        (pair_raw.count == 2'd2 && pair_raw.first.kind == KIND_SAMPLE
            && pair_raw.second.kind == KIND_SAMPLE)
            |-> (pair_raw.first.chan != pair_raw.second.chan))
        else $error("two samples from one byte share a channel");

endmodule

`default_nettype wire

// File: rtl/core/rdss_out_fifo.sv
// Output queue for the record deframer: takes up to two results per cycle,
// hands out one per beat. Depends on rdss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rdss_out_fifo (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire rdss_pkg::pair_t pair,
    output logic                 room_for_pair,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output rdss_pkg::result_t    out_res
);
    import rdss_pkg::*;

    result_t          mem [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic [1:0]       push_n;
    logic             pop;

    assign push_n        = push ? pair.count : 2'd0;
    assign pop           = out_valid && out_ready;
    assign out_valid     = (count_reg != '0);
    assign out_res       = mem[rd_ptr_reg];
    assign room_for_pair = (count_reg <= CNT_W'(FIFO_DEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_n);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(push_n) - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
            mem[wr_ptr_reg] <= pair.first;
        if (push_n == 2'd2)
            mem[wr_ptr_reg + PTR_W'(1)] <= pair.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_fill_bound : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(FIFO_DEPTH))
        else $error("output queue over-filled");

    a_push_room : assert property (@(posedge clk) disable iff (!rst_n)
        (push_n != 2'd0) |-> (count_reg <= CNT_W'(FIFO_DEPTH - 2)))
        else $error("results pushed without room for a pair");

    a_pop_drains : assert property (@(posedge clk) disable iff (!rst_n)
        (pop && push_n == 2'd0) |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("fill count did not drop after a lone pop");

endmodule

`default_nettype wire

// File: rtl/core/record_deframer_sample_scaler.sv
// Top level of the record deframer and sample scaler: stream ports, the
// deframer state machine and the output queue. Depends on rdss_pkg,
// rdss_deframer and rdss_out_fifo.
//
//  Channel | Dir | Beat contents
//  --------+-----+-----------------------------------------------------------
//  s_*     | in  | tdata[7:0] in_byte
//  m_*     | out | tdata value, header_index, channel; tuser kind; tlast
//
// At most one byte is accepted per cycle; a byte yields zero, one or two results,
// each leaving as one output beat. The state update and the 127/100 scaling
// (one 8x13 constant multiply) sit between the state registers and a
// four-entry result queue. s_tready is high while the queue has room for two
// results, so with m_tready held high the block takes a byte every cycle.
// Reset (rst_n low, asynchronous) returns to hunting for the first separator
// pair and empties the queue. Stalls on m_tready hold queued beats in place
// and drop s_tready once fewer than two entries are free.
`timescale 1ns / 1ps
`default_nettype none

module record_deframer_sample_scaler #(
    parameter int HEADER_BYTES = rdss_pkg::HEADER_BYTES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
    // Result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [7:0] value, [12:8] header_index,
                                        // [13] channel, [15:14] zero
    output logic [1:0]       m_tuser,   // [1:0] kind
    output logic             m_tlast    // last_of_run
);
    import rdss_pkg::*;

    logic    in_accept;
    logic    room_for_pair;
    pair_t   pair;
    result_t out_res;

    // Advance the deframer only on an accepted input beat
    assign s_tready  = room_for_pair;
    assign in_accept = s_tvalid && s_tready;

    rdss_deframer #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_deframer (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (in_accept),
        .in_byte (s_tdata),
        .pair    (pair)
    );

    // Queue the results so the input side keeps flowing while the output stalls
    rdss_out_fifo u_out_fifo (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (in_accept),
        .pair          (pair),
        .room_for_pair (room_for_pair),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_res       (out_res)
    );

    assign m_tdata = {2'b00, out_res.chan, out_res.hidx, out_res.value};
    assign m_tuser = out_res.kind;
    assign m_tlast = out_res.last;

endmodule

`default_nettype wire

// File: tb/tb_record_deframer_sample_scaler.sv
// Self-checking testbench for record_deframer_sample_scaler: drives a byte stream,
// predicts every result beat and compares it with the block's output stream.
// Depends on rdss_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_record_deframer_sample_scaler;

    import rdss_pkg::*;

    localparam int HDR          = HEADER_BYTES_DEF;
    localparam int SCALE_NUM    = 127;
    localparam int SCALE_DEN    = 100;
    localparam int STALL_LIMIT  = 5000;   // cycles with no beat on either side
    localparam int HOLD_CYCLES  = 300;    // long receiver hold-off
    localparam int DRAIN_CYCLES = 8;      // queue depth plus margin
    localparam int TOTAL_ITEMS  = 1800;
    localparam int MAX_REPORTS  = 30;

    // Framing states of the predictor
    typedef enum logic [1:0] {
        ST_HUNT = 2'd0,
        ST_SKIP = 2'd1,
        ST_REC  = 2'd2
    } frame_state_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata  = 8'h00;
    logic        m_tready = 1'b0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [15:0] m_tdata;
    wire  [1:0]  m_tuser;
    wire         m_tlast;

    record_deframer_sample_scaler dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Predictor state, mirroring the block after reset
    frame_state_t frame_st   = ST_HUNT;
    logic         sep_held   = 1'b0;
    logic [4:0]   rec_offset = 5'd0;
    logic         next_chan  = 1'b0;

    result_t pending_results[$];
    int      error_count = 0;
    int      bytes_sent  = 0;
    int      idle_cycles = 0;
    int      hold_left   = 0;
    bit      quiet       = 1'b0;   // no idling on either side
    bit      hold_req    = 1'b0;   // ask the receiver for a long hold-off

    // Turn one record byte into a header beat or a scaled sample beat
    function automatic result_t data_result(input logic [7:0] b);
        result_t r;
        int      scaled;
        r = '0;
        if (rec_offset < HDR)
        begin
            r.kind     = KIND_HEADER;
            r.value    = b;
            r.hidx     = rec_offset;
            rec_offset = rec_offset + 5'd1;
        end
        else
        begin
            scaled = (int'(b) * SCALE_NUM) / SCALE_DEN;
            if (scaled > int'(SAMPLE_MAX))
                scaled = int'(SAMPLE_MAX);
            r.kind    = KIND_SAMPLE;
            r.value   = scaled[7:0];
            r.chan    = next_chan;
            next_chan = ~next_chan;
        end
        return r;
    endfunction

    // Advance the framing state by one accepted byte and queue its results
    task automatic deframe_byte(input logic [7:0] b);
        result_t res [2];
        int      n;
        logic    is_sep;
        n      = 0;
        is_sep = (b == SEP_BYTE);
        case (frame_st)
            ST_SKIP:
            begin
                sep_held = 1'b0;
                if (!is_sep)
                begin
                    frame_st   = ST_REC;
                    rec_offset = 5'd0;
                    next_chan  = 1'b0;
                    res[n]     = data_result(b);
                    n++;
                end
            end
            ST_REC:
            begin
                if (sep_held)
                begin
                    sep_held = 1'b0;
                    if (is_sep)
                    begin
                        // second byte of the terminator: record end
                        res[n]      = '0;
                        res[n].kind = KIND_END;
                        n++;
                        frame_st = ST_SKIP;
                    end
                    else
                    begin
                        // the held separator byte was data after all
                        res[n] = data_result(SEP_BYTE);
                        n++;
                        res[n] = data_result(b);
                        n++;
                    end
                end
                else if (is_sep && rec_offset >= TERM_MIN_OFFSET)
                    sep_held = 1'b1;
                else
                begin
                    res[n] = data_result(b);
                    n++;
                end
            end
            default:
            begin
                frame_st = ST_HUNT;
                if (is_sep && sep_held)
                begin
                    frame_st = ST_SKIP;
                    sep_held = 1'b0;
                end
                else
                    sep_held = is_sep;
            end
        endcase
        if (n > 0)
            res[n-1].last = 1'b1;
        for (int i = 0; i < n; i++)
            pending_results.insert(pending_results.size(), res[i]);
    endtask

    // Monitor both streams: predict on every input beat, check every output beat
    always @(posedge clk)
    begin : monitor
        result_t got;
        result_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                deframe_byte(s_tdata);
            if (m_tvalid && m_tready)
            begin
                got.kind  = kind_t'(m_tuser);
                got.value = m_tdata[7:0];
                got.hidx  = m_tdata[12:8];
                got.chan  = m_tdata[13];
                got.last  = m_tlast;
                if (pending_results.size() == 0)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display({"%0t: unexpected beat, expected none, actual kind %0d",
                                  " value %h hidx %0d chan %0b last %0b"},
                                 $time, got.kind, got.value, got.hidx, got.chan, got.last);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got !== want || m_tdata[15:14] !== 2'b00)
                    begin
                        error_count++;
                        if (error_count <= MAX_REPORTS)
                            $display({"%0t: mismatch, expected kind %0d value %h",
                                      " hidx %0d chan %0b last %0b pad 0,",
                                      " actual kind %0d value %h hidx %0d chan %0b",
                                      " last %0b pad %0d"},
                                     $time, want.kind, want.value, want.hidx, want.chan,
                                     want.last, got.kind, got.value, got.hidx, got.chan,
                                     got.last, m_tdata[15:14]);
                    end
                end
            end
        end
    end

    // Watchdog: end the run if no beat moves on either side for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // Receiver: random stalls, or a long hold-off counted here when asked for
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left--;
        end
        else if (hold_req)
        begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end
        else
            m_tready <= quiet || ($urandom_range(0, 99) >= 20);
    end

    // Offer one byte, with an occasional gap first, and hold it until accepted
    task automatic send_byte(input logic [7:0] b);
        if (!quiet && $urandom_range(0, 99) < 12)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_seq(input logic [7:0] seq[$]);
        foreach (seq[i])
            send_byte(seq[i]);
    endtask

    // Stop offering, wait for every expected beat, then let the pipeline settle
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // One record: a non-separator opening byte, random content with a given
    // share of separator bytes, and optionally a terminator plus a skipped run
    task automatic send_record(input int len, input int sep_pct, input bit terminate);
        send_byte(8'($urandom_range(0, 254)));
        for (int i = 1; i < len; i++)
        begin
            if ($urandom_range(0, 99) < sep_pct)
                send_byte(SEP_BYTE);
            else
                send_byte(8'($urandom_range(0, 255)));
        end
        if (terminate)
        begin
            send_byte(SEP_BYTE);
            send_byte(SEP_BYTE);
            repeat ($urandom_range(0, 3)) send_byte(SEP_BYTE);
        end
    endtask

    // Leading garbage: a lone separator byte does not count, a pair does,
    // and further separator bytes are skipped
    task automatic test_hunt_prefix();
        send_seq('{8'h00, 8'hFF, 8'h12, 8'hFE, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
        wait_drained();
    endtask

    // Short record: separator byte at offset one goes out at once, a held one
    // is released by a data byte, then the terminator closes the record
    task automatic test_short_record();
        send_seq('{8'h01, 8'hFF, 8'h00, 8'hFF, 8'h05, 8'hFF, 8'hFF, 8'hFF});
        wait_drained();
    endtask

    // Full header, then body samples at the scaling extremes and the
    // saturation edge, a released separator byte as a sample, and the end
    task automatic test_long_record();
        for (int i = 0; i < HDR; i++)
            send_byte((i == 5) ? SEP_BYTE : 8'(i * 9 + 1));
        send_seq('{8'h00, 8'h64, 8'h65, 8'hFF, 8'h7F, 8'h01, 8'h63, 8'hFF, 8'hFF});
        wait_drained();
    endtask

    // Hold the receiver off while bytes keep coming, so the queue fills
    // and the input stalls
    task automatic test_backpressure();
        hold_req = 1'b1;
        send_record(70, 5, 1'b1);
        wait_drained();
    endtask

    // Mostly well-formed records with random content, some noise bursts and
    // records left without a terminator; a stretch in the middle runs without idling
    task automatic test_random_stream();
        int pick;
        int len;
        while (bytes_sent < TOTAL_ITEMS)
        begin
            quiet = (bytes_sent > 800 && bytes_sent < 1100);
            pick  = $urandom_range(0, 99);
            if (pick < 10)
            begin
                repeat ($urandom_range(1, 8))
                    send_byte(($urandom_range(0, 1) == 1) ? SEP_BYTE
                                                          : 8'($urandom_range(0, 255)));
            end
            else
            begin
                len = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 40)
                                                   : $urandom_range(41, 90);
                send_record(len, $urandom_range(0, 25), $urandom_range(0, 99) < 85);
            end
        end
        quiet = 1'b0;
        wait_drained();
    endtask

    // Close whatever is open, then leave a record unterminated with a held
    // separator byte that never gets reported
    task automatic test_open_record();
        send_seq('{8'hFF, 8'hFF, 8'hFF, 8'h3C, 8'h00, 8'hFF});
        wait_drained();
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        test_hunt_prefix();
        test_short_record();
        test_long_record();
        test_backpressure();
        test_random_stream();
        test_open_record();
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/rdss_pkg.sv
rtl/core/rdss_deframer.sv
rtl/core/rdss_out_fifo.sv
rtl/core/record_deframer_sample_scaler.sv
tb/tb_record_deframer_sample_scaler.sv
